@@ hw/rtl/emrc_pkg.sv @@
// Shared types, constants and state encoding for the element mean radius classifier.
package emrc_pkg;

    localparam int COORD_W   = 32;
    localparam int RADIUS_W  = 31;
    localparam int SUM_W     = 35;
    localparam int FRAC_BITS = 26;
    localparam int MCAND_W   = 33;
    localparam int MPLIER_W  = 32;
    localparam int PROD_W    = MCAND_W + MPLIER_W;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int CORNERS   = 8;
    localparam int CNT_W     = $clog2(CORNERS);
    localparam int STEPS     = MPLIER_W / 2;
    localparam int STEP_W    = $clog2(STEPS);
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    localparam logic [RADIUS_W-1:0] RADIUS_SAT       = {RADIUS_W{1'b1}};
    localparam logic [RADIUS_W-1:0] RST_DEPTH_SCALE  = RADIUS_W'(30198989);
    localparam logic [RADIUS_W-1:0] RST_RADIUS_FLOOR = RADIUS_W'(36909875);
    localparam logic [RADIUS_W-1:0] RST_IFACE_RADIUS = RADIUS_W'(60156788);

    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_SCALE = 2'd1,
        REG_FLOOR = 2'd2,
        REG_IFACE = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_ROOT,
        S_ACC
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_vertex;

    typedef struct packed {
        logic [RADIUS_W-1:0] mean_radius;
        logic                in_upper_part;
    } t_result;

endpackage

@@ hw/rtl/emrc_mul.sv @@
// Radix-4 serial signed multiplier lane: two multiplier bits per cycle while i_step is high.
module emrc_mul
    import emrc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic                       i_step,
    input  logic signed [MCAND_W-1:0]  i_mcand,
    input  logic [MPLIER_W-1:0]        i_mplier,
    output logic signed [PROD_W-1:0]   o_prod
);

    localparam int HI_W = MCAND_W + 2;

    logic signed [MCAND_W-1:0]         r_mcand;
    logic [HI_W+MPLIER_W-1:0]          r_p;
    logic [HI_W+MPLIER_W-1:0]          n_p;
    logic signed [HI_W-1:0]            w_a;
    logic signed [HI_W-1:0]            w_part;
    logic signed [HI_W-1:0]            w_hi;

    always_comb begin
        w_a    = HI_W'(r_mcand);
        w_part = (r_p[0] ? w_a : '0) + (r_p[1] ? (w_a <<< 1) : '0);
        w_hi   = signed'(r_p[HI_W+MPLIER_W-1:MPLIER_W]) + w_part;
        n_p    = {{2{w_hi[HI_W-1]}}, w_hi, r_p[MPLIER_W-1:2]};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mcand <= i_mcand;
            r_p     <= {{HI_W{1'b0}}, i_mplier};
        end else if (i_step) begin
            r_p <= n_p;
        end
    end

    assign o_prod = signed'(r_p[PROD_W-1:0]);

endmodule

@@ hw/rtl/emrc_sqrt.sv @@
// Floor integer square root, two root bits per cycle while i_step is high.
module emrc_sqrt
    import emrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_step,
    input  logic [SQ_W-1:0]   i_radicand,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 3;

    logic [SQ_W-1:0]   r_rad;
    logic [REM_W-2:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  w_rem  [3];
    logic [ROOT_W-1:0] w_root [3];
    logic [REM_W-1:0]  w_sh;
    logic [REM_W-1:0]  w_trial;

    always_comb begin
        w_rem[0]  = {1'b0, r_rem};
        w_root[0] = r_root;
        w_sh      = '0;
        w_trial   = '0;
        for (int k = 0; k < 2; k++) begin
            w_sh    = {w_rem[k][REM_W-3:0], r_rad[SQ_W-1-2*k -: 2]};
            w_trial = {1'b0, w_root[k], 2'b01};
            if (w_sh >= w_trial) begin
                w_rem[k+1]  = w_sh - w_trial;
                w_root[k+1] = {w_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                w_rem[k+1]  = w_sh;
                w_root[k+1] = {w_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_step) begin
            r_rad  <= {r_rad[SQ_W-5:0], 4'b0000};
            r_rem  <= w_rem[2][REM_W-2:0];
            r_root <= w_root[2];
        end
    end

    assign o_root = r_root;

endmodule

@@ hw/rtl/element_mean_radius_classifier.sv @@
// Top level: vertex radius, eight-vertex mean and interface classification.
// One vertex beat is taken at a time. In spherical mode a vertex goes from accept to the next
// accept through radix-4 serial multiplication (three lanes square x, y and z side by side),
// summing of the squares, the two-bit-per-cycle square root, accumulation and an idle state.
// In linear mode the root is skipped. A finished mean waits in an output register; only the
// eighth vertex of the next element stalls if that register has not been taken.
module element_mean_radius_classifier
    import emrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vtx_valid,
    output logic              o_vtx_ready,
    input  t_vertex           i_vtx,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_state                r_state;
    t_state                n_state;
    logic [STEP_W-1:0]     r_step;
    logic [CNT_W-1:0]      r_vcnt;
    logic [SUM_W-1:0]      r_sum;
    logic [RADIUS_W-1:0]   r_lin;
    logic                  r_res_valid;
    t_result               r_res;

    logic                  r_spherical;
    logic [RADIUS_W-1:0]   r_scale;
    logic [RADIUS_W-1:0]   r_floor;
    logic [RADIUS_W-1:0]   r_iface;

    logic                  w_load;
    logic                  w_mul_step;
    logic                  w_root_load;
    logic                  w_root_step;
    logic                  w_acc;
    logic                  w_last;
    logic                  w_out_free;
    logic                  w_cfg_wr;

    logic [COORD_W-1:0]        w_mx;
    logic [COORD_W-1:0]        w_my;
    logic [COORD_W-1:0]        w_mz;
    logic signed [MCAND_W-1:0] w_a0;
    logic [MPLIER_W-1:0]       w_b0;
    logic signed [PROD_W-1:0]  w_p0;
    logic signed [PROD_W-1:0]  w_p1;
    logic signed [PROD_W-1:0]  w_p2;
    logic [SQ_W-1:0]           w_sq;
    logic [ROOT_W-1:0]         w_root;
    logic signed [PROD_W-FRAC_BITS:0] w_lin;
    logic [RADIUS_W-1:0]       w_lin_sat;
    logic [RADIUS_W-1:0]       w_radius;
    logic [SUM_W-1:0]          w_sum;
    logic [RADIUS_W-1:0]       w_mean;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spherical <= 1'b0;
            r_scale     <= RST_DEPTH_SCALE;
            r_floor     <= RST_RADIUS_FLOOR;
            r_iface     <= RST_IFACE_RADIUS;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_MODE:  r_spherical <= pwdata[0];
                REG_SCALE: r_scale     <= pwdata[RADIUS_W-1:0];
                REG_FLOOR: r_floor     <= pwdata[RADIUS_W-1:0];
                REG_IFACE: r_iface     <= pwdata[RADIUS_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_MODE:  prdata = {{(APB_DW-1){1'b0}}, r_spherical};
            REG_SCALE: prdata = {1'b0, r_scale};
            REG_FLOOR: prdata = {1'b0, r_floor};
            REG_IFACE: prdata = {1'b0, r_iface};
            default:   prdata = '0;
        endcase
    end

    // datapath
    assign w_mx = i_vtx.coord_x[COORD_W-1] ? (~i_vtx.coord_x + 1'b1) : i_vtx.coord_x;
    assign w_my = i_vtx.coord_y[COORD_W-1] ? (~i_vtx.coord_y + 1'b1) : i_vtx.coord_y;
    assign w_mz = i_vtx.coord_z[COORD_W-1] ? (~i_vtx.coord_z + 1'b1) : i_vtx.coord_z;
    assign w_a0 = r_spherical ? signed'({1'b0, w_mz}) : MCAND_W'(i_vtx.coord_z);
    assign w_b0 = r_spherical ? w_mz : {1'b0, r_scale};

    emrc_mul u_mul_z (
        .i_clk    (i_clk),
        .i_load   (w_load),
        .i_step   (w_mul_step),
        .i_mcand  (w_a0),
        .i_mplier (w_b0),
        .o_prod   (w_p0)
    );

    emrc_mul u_mul_x (
        .i_clk    (i_clk),
        .i_load   (w_load),
        .i_step   (w_mul_step),
        .i_mcand  (signed'({1'b0, w_mx})),
        .i_mplier (w_mx),
        .o_prod   (w_p1)
    );

    emrc_mul u_mul_y (
        .i_clk    (i_clk),
        .i_load   (w_load),
        .i_step   (w_mul_step),
        .i_mcand  (signed'({1'b0, w_my})),
        .i_mplier (w_my),
        .o_prod   (w_p2)
    );

    assign w_sq = w_p0[SQ_W-1:0] + w_p1[SQ_W-1:0] + w_p2[SQ_W-1:0];

    emrc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_load     (w_root_load),
        .i_step     (w_root_step),
        .i_radicand (w_sq),
        .o_root     (w_root)
    );

    // linear: floor shift, add floor radius, clamp
    always_comb begin
        w_lin = signed'({w_p0[PROD_W-1], w_p0[PROD_W-1:FRAC_BITS]})
              + signed'({{(PROD_W-FRAC_BITS-RADIUS_W+1){1'b0}}, r_floor});
        if (w_lin[PROD_W-FRAC_BITS]) begin
            w_lin_sat = '0;
        end else if (|w_lin[PROD_W-FRAC_BITS-1:RADIUS_W]) begin
            w_lin_sat = RADIUS_SAT;
        end else begin
            w_lin_sat = w_lin[RADIUS_W-1:0];
        end
    end

    assign w_radius   = r_spherical ? (w_root[ROOT_W-1] ? RADIUS_SAT : w_root[RADIUS_W-1:0])
                                    : r_lin;
    assign w_sum      = r_sum + SUM_W'(w_radius);
    assign w_mean     = w_sum[CNT_W+RADIUS_W-1:CNT_W];
    assign w_last     = (r_vcnt == CNT_W'(CORNERS - 1));
    assign w_out_free = !r_res_valid || i_res_ready;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_vtx_valid) n_state = S_MUL;
            S_MUL:  if (&r_step) n_state = S_ADD;
            S_ADD:  n_state = r_spherical ? S_ROOT : S_ACC;
            S_ROOT: if (&r_step) n_state = S_ACC;
            S_ACC:  if (!w_last || w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_vtx_ready = 1'b0;
        w_mul_step  = 1'b0;
        w_root_load = 1'b0;
        w_root_step = 1'b0;
        w_acc       = 1'b0;
        unique case (r_state)
            S_IDLE: o_vtx_ready = 1'b1;
            S_MUL:  w_mul_step  = 1'b1;
            S_ADD:  w_root_load = 1'b1;
            S_ROOT: w_root_step = 1'b1;
            S_ACC:  w_acc       = !w_last || w_out_free;
            default: ;
        endcase
    end

    assign w_load = i_vtx_valid & o_vtx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_vcnt      <= '0;
            r_sum       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (w_mul_step || w_root_step) ? r_step + 1'b1 : '0;
            if (w_acc) begin
                if (w_last) begin
                    r_vcnt      <= '0;
                    r_sum       <= '0;
                    r_res_valid <= 1'b1;
                end else begin
                    r_vcnt <= r_vcnt + 1'b1;
                    r_sum  <= w_sum;
                    if (i_res_ready) r_res_valid <= 1'b0;
                end
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_root_load) r_lin <= w_lin_sat;
        if (w_acc && w_last) begin
            r_res.mean_radius   <= w_mean;
            r_res.in_upper_part <= (w_mean >= r_iface);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
